/* rtl/core/icmpx_pkg.sv */
`default_nettype none
// ============================================================================
// ICMPv6 to ICMPv4 header translation package
// Shared message codes, result types and the Parameter Problem pointer map.
// ============================================================================
package icmpx_pkg;

    localparam int unsigned MTU_W     = 32;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IN_DEV_MTU   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OUT_PATH_MTU = 8'd1;

    localparam logic [MTU_W-1:0] MTU_RESET      = 32'hffff_ffff;
    localparam logic [MTU_W-1:0] IPV6_IPV4_DIFF = 32'd20;

    // ICMPv6 types and codes.
    localparam logic [7:0] V6_DEST_UNREACH  = 8'd1;
    localparam logic [7:0] V6_PKT_TOO_BIG   = 8'd2;
    localparam logic [7:0] V6_TIME_EXCEEDED = 8'd3;
    localparam logic [7:0] V6_PARAM_PROB    = 8'd4;
    localparam logic [7:0] V6_ECHO_REQUEST  = 8'd128;
    localparam logic [7:0] V6_ECHO_REPLY    = 8'd129;

    localparam logic [7:0] V6_DU_NO_ROUTE      = 8'd0;
    localparam logic [7:0] V6_DU_ADMIN_PROHIB  = 8'd1;
    localparam logic [7:0] V6_DU_BEYOND_SCOPE  = 8'd2;
    localparam logic [7:0] V6_DU_ADDR_UNREACH  = 8'd3;
    localparam logic [7:0] V6_DU_PORT_UNREACH  = 8'd4;
    localparam logic [7:0] V6_PP_ERR_HEADER    = 8'd0;
    localparam logic [7:0] V6_PP_UNKNOWN_NEXT  = 8'd1;

    // ICMPv4 types and codes.
    localparam logic [7:0] V4_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] V4_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] V4_ECHO_REQUEST  = 8'd8;
    localparam logic [7:0] V4_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] V4_PARAM_PROB    = 8'd12;

    localparam logic [7:0] V4_CODE_ZERO         = 8'd0;
    localparam logic [7:0] V4_DU_HOST_UNREACH   = 8'd1;
    localparam logic [7:0] V4_DU_PROTO_UNREACH  = 8'd2;
    localparam logic [7:0] V4_DU_PORT_UNREACH   = 8'd3;
    localparam logic [7:0] V4_DU_FRAG_NEEDED    = 8'd4;
    localparam logic [7:0] V4_DU_HOST_PROHIB    = 8'd10;

    // Inner packet work that follows the header.
    localparam logic [1:0] WORK_NONE        = 2'd0;
    localparam logic [1:0] WORK_WITH_EXT    = 2'd1;
    localparam logic [1:0] WORK_WITHOUT_EXT = 2'd2;

    typedef struct packed {
        logic             dropped;
        logic [7:0]       v4_type;
        logic [7:0]       v4_code;
        logic [MTU_W-1:0] v4_rest_word;
        logic [1:0]       inner_work;
    } t_v4_hdr;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_ptr_map;

    // Maps an IPv6 header pointer onto the matching IPv4 header offset, or flags a miss.
    function automatic t_ptr_map map_pointer(input logic [MTU_W-1:0] ptr);
        t_ptr_map res;
        res.hit   = 1'b0;
        res.value = 8'd0;
        if (ptr <= 32'd39) begin
            res.hit = 1'b1;
            case (ptr[5:0])
                6'd0: res.value = 8'd0;
                6'd1: res.value = 8'd1;
                6'd2, 6'd3: res.hit = 1'b0;
                6'd4, 6'd5: res.value = 8'd2;
                6'd6: res.value = 8'd9;
                6'd7: res.value = 8'd8;
                default: begin
                    res.value = (ptr[5:0] >= 6'd24) ? 8'd16 : 8'd12;
                end
            endcase
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/icmpx_cfg_regs.sv */
`default_nettype none
// ============================================================================
// ICMPx configuration registers
// Holds the device and path MTU and keeps the registered MTU bound that
// Packet Too Big translation compares against.
// ============================================================================
module icmpx_cfg_regs (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    input  wire  [icmpx_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [icmpx_pkg::MTU_W-1:0]          i_cfg_data,
    output logic [icmpx_pkg::MTU_W-1:0]          o_mtu_bound
);
    import icmpx_pkg::*;

    logic [MTU_W-1:0] r_in_dev_mtu;
    logic [MTU_W-1:0] r_out_path_mtu;
    logic [MTU_W-1:0] r_mtu_bound;
    logic [MTU_W-1:0] n_dev_less;
    logic [MTU_W-1:0] n_mtu_bound;

    assign n_dev_less  = r_in_dev_mtu - IPV6_IPV4_DIFF;
    assign n_mtu_bound = (n_dev_less < r_out_path_mtu) ? n_dev_less : r_out_path_mtu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dev_mtu   <= MTU_RESET;
            r_out_path_mtu <= MTU_RESET;
            r_mtu_bound    <= MTU_RESET - IPV6_IPV4_DIFF;
        end else begin
            r_mtu_bound <= n_mtu_bound;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IDX_IN_DEV_MTU) begin
                    r_in_dev_mtu <= i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_OUT_PATH_MTU) begin
                    r_out_path_mtu <= i_cfg_data;
                end
            end
        end
    end

    assign o_mtu_bound = r_mtu_bound;

endmodule
`default_nettype wire

/* rtl/core/icmpx_map.sv */
`default_nettype none
// ============================================================================
// ICMPx header mapper
// Maps one registered ICMPv6 header onto its ICMPv4 header or a drop.
// ============================================================================
module icmpx_map (
    input  wire  [7:0]                   i_v6_type,
    input  wire  [7:0]                   i_v6_code,
    input  wire  [icmpx_pkg::MTU_W-1:0]  i_v6_rest_word,
    input  wire  [icmpx_pkg::MTU_W-1:0]  i_mtu_bound,
    output icmpx_pkg::t_v4_hdr           o_hdr
);
    import icmpx_pkg::*;

    logic [MTU_W-1:0] pkt_mtu;
    logic [MTU_W-1:0] min_mtu;
    t_ptr_map         ptr_map;
    t_v4_hdr          hdr;
    logic             drop;

    assign pkt_mtu = i_v6_rest_word - IPV6_IPV4_DIFF;
    assign min_mtu = (pkt_mtu < i_mtu_bound) ? pkt_mtu : i_mtu_bound;
    assign ptr_map = map_pointer(i_v6_rest_word);

    always_comb begin
        hdr  = '0;
        drop = 1'b0;
        case (i_v6_type)
            V6_ECHO_REQUEST, V6_ECHO_REPLY: begin
                hdr.v4_type      = (i_v6_type == V6_ECHO_REQUEST) ? V4_ECHO_REQUEST
                                                                  : V4_ECHO_REPLY;
                hdr.v4_code      = V4_CODE_ZERO;
                hdr.v4_rest_word = i_v6_rest_word;
                hdr.inner_work   = WORK_NONE;
            end
            V6_DEST_UNREACH: begin
                hdr.v4_type    = V4_DEST_UNREACH;
                hdr.inner_work = WORK_WITH_EXT;
                if (i_v6_code inside {V6_DU_NO_ROUTE, V6_DU_BEYOND_SCOPE,
                                      V6_DU_ADDR_UNREACH}) begin
                    hdr.v4_code = V4_DU_HOST_UNREACH;
                end else if (i_v6_code == V6_DU_ADMIN_PROHIB) begin
                    hdr.v4_code = V4_DU_HOST_PROHIB;
                end else if (i_v6_code == V6_DU_PORT_UNREACH) begin
                    hdr.v4_code = V4_DU_PORT_UNREACH;
                end else begin
                    drop = 1'b1;
                end
            end
            V6_TIME_EXCEEDED: begin
                hdr.v4_type    = V4_TIME_EXCEEDED;
                hdr.v4_code    = i_v6_code;
                hdr.inner_work = WORK_WITH_EXT;
            end
            V6_PKT_TOO_BIG: begin
                hdr.v4_type      = V4_DEST_UNREACH;
                hdr.v4_code      = V4_DU_FRAG_NEEDED;
                hdr.v4_rest_word = {16'd0, min_mtu[15:0]};
                hdr.inner_work   = WORK_WITHOUT_EXT;
            end
            V6_PARAM_PROB: begin
                hdr.inner_work = WORK_WITHOUT_EXT;
                if (i_v6_code == V6_PP_ERR_HEADER) begin
                    hdr.v4_type      = V4_PARAM_PROB;
                    hdr.v4_code      = V4_CODE_ZERO;
                    hdr.v4_rest_word = {ptr_map.value, 24'd0};
                    drop             = !ptr_map.hit;
                end else if (i_v6_code == V6_PP_UNKNOWN_NEXT) begin
                    hdr.v4_type = V4_DEST_UNREACH;
                    hdr.v4_code = V4_DU_PROTO_UNREACH;
                end else begin
                    drop = 1'b1;
                end
            end
            default: begin
                drop = 1'b1;
            end
        endcase

        if (drop) begin
            o_hdr         = '0;
            o_hdr.dropped = 1'b1;
        end else begin
            o_hdr         = hdr;
            o_hdr.dropped = 1'b0;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/icmpv6_to_icmpv4_header_xlat.sv */
`default_nettype none
// ============================================================================
// ICMPv6 to ICMPv4 header translator
// Two-stage pipeline: input register, header mapping, result register.
// ============================================================================
// The block accepts one ICMPv6 header per clock while o_in_ready is high and
// returns, in order, one ICMPv4 header or a drop flag per request through the
// input and result registers. The rate is one request per cycle, set by those
// registers, which advance whenever the result register is empty or being
// taken. The Packet Too Big MTU bound, the registered minimum of path MTU
// and device MTU less 20, follows a write through the MTU and bound registers.
module icmpv6_to_icmpv4_header_xlat (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [icmpx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [icmpx_pkg::MTU_W-1:0]         i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [7:0]                          i_v6_type,
    input  wire  [7:0]                          i_v6_code,
    input  wire  [icmpx_pkg::MTU_W-1:0]         i_v6_rest_word,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_dropped,
    output logic [7:0]                          o_v4_type,
    output logic [7:0]                          o_v4_code,
    output logic [icmpx_pkg::MTU_W-1:0]         o_v4_rest_word,
    output logic [1:0]                          o_inner_work
);
    import icmpx_pkg::*;

    logic             r_s1_valid;
    logic [7:0]       r_s1_type;
    logic [7:0]       r_s1_code;
    logic [MTU_W-1:0] r_s1_rest;
    logic             r_out_valid;
    t_v4_hdr          r_out_hdr;
    t_v4_hdr          n_out_hdr;
    logic [MTU_W-1:0] mtu_bound;
    logic             out_adv;
    logic             in_take;

    icmpx_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mtu_bound (mtu_bound)
    );

    icmpx_map u_map (
        .i_v6_type      (r_s1_type),
        .i_v6_code      (r_s1_code),
        .i_v6_rest_word (r_s1_rest),
        .i_mtu_bound    (mtu_bound),
        .o_hdr          (n_out_hdr)
    );

    assign out_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || out_adv;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_type <= i_v6_type;
            r_s1_code <= i_v6_code;
            r_s1_rest <= i_v6_rest_word;
        end
        if (out_adv && r_s1_valid) begin
            r_out_hdr <= n_out_hdr;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dropped      = r_out_hdr.dropped;
    assign o_v4_type      = r_out_hdr.v4_type;
    assign o_v4_code      = r_out_hdr.v4_code;
    assign o_v4_rest_word = r_out_hdr.v4_rest_word;
    assign o_inner_work   = r_out_hdr.inner_work;

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> (o_v4_type == V4_ECHO_REPLY &&
            o_v4_code == V4_CODE_ZERO && o_v4_rest_word == '0 &&
            o_inner_work == WORK_NONE))
        else $error("Dropped result carries nonzero fields.");

    a_work_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_inner_work == WORK_NONE || o_inner_work == WORK_WITH_EXT ||
            o_inner_work == WORK_WITHOUT_EXT))
        else $error("Inner work code out of range.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("Pipeline not empty after reset.");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_adv) |=> o_out_valid)
        else $error("Pending request lost between stages.");

endmodule
`default_nettype wire
